@@ design/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// plain implication checked on every rising clock edge outside reset
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// implication whose consequent is checked in the next cycle
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ design/p2rde_pkg.sv @@
// package with command codes and state types of the raster draw engine
`default_nettype none
package p2rde_pkg;
    localparam int KindW = 3;
    localparam int CoordW = 16;
    localparam int AddrW = 17;

    typedef enum logic [2:0] {
        K_CLEAR = 3'd0,
        K_COLOR = 3'd1,
        K_FILL  = 3'd2,
        K_LINE  = 3'd3,
        K_RECT  = 3'd4,
        K_READ  = 3'd5,
        K_NOP6  = 3'd6,
        K_NOP7  = 3'd7
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_FILL_ROW,
        S_FILL_RD,
        S_FILL_WR,
        S_LINE_SETUP,
        S_LINE_RD,
        S_LINE_WR,
        S_READ,
        S_READ_WAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [KindW-1:0]  kind;
        logic [CoordW-1:0] start_x;
        logic [CoordW-1:0] start_y;
        logic [CoordW-1:0] end_x_or_width;
        logic [CoordW-1:0] end_y_or_height;
        logic [1:0]        new_color;
        logic [AddrW-1:0]  byte_address;
    } t_cmd;

    typedef struct packed {
        logic [7:0] read_byte;
        logic [1:0] color_now;
    } t_res;

    localparam logic [7:0] ByteWhite = 8'hFF;
    localparam logic [1:0] ColorBlack = 2'd3;
endpackage
`default_nettype wire

@@ design/p2rde_if.sv @@
// valid/ready channel carrying one word of a given payload type
`default_nettype none
interface p2rde_cmd_if;
    import p2rde_pkg::*;
    logic valid;
    logic ready;
    t_cmd data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface p2rde_res_if;
    import p2rde_pkg::*;
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ design/packed_2bpp_raster_draw_engine_unit.sv @@
// packed 2bpp raster draw engine: frame store, fill, line and readback
// Usage: commands arrive on i_cmd (valid/ready), one result word per command
// leaves on o_res (valid/ready). A command is taken only when the engine is
// idle; the result holds in an output register until the sink takes it.
// Each command walks through its own states before o_res.valid rises,
// each pixel drawn as a read-modify-write of its byte in the frame store:
//   set color / unused kinds: straight to the done state
//   read byte: read, wait for the frame store, done
//   clear: one byte per cycle over the whole frame
//   fill: a read and a write per clipped pixel, a row step per clipped row
//   line: a read and a write per point walked, points off the frame included
//   outline: four lines back to back
// The next command is taken once the previous result word has been taken.
// Reset: a clearing pass writes 0xFF over the frame, one byte per cycle,
// while no command is accepted; colour is black.
// A stalled result sink holds the engine with the word steady on o_res.
`default_nettype none
module packed_2bpp_raster_draw_engine_unit #(
    parameter int DISPLAY_WIDTH  = 800,
    parameter int DISPLAY_HEIGHT = 480
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    p2rde_cmd_if.sink   i_cmd,
    p2rde_res_if.source o_res
);
    import p2rde_pkg::*;

    localparam int FrameBytes = (DISPLAY_WIDTH * DISPLAY_HEIGHT + 3) / 4;
    localparam int FaW = $clog2(FrameBytes);
    localparam int PixW = $clog2(DISPLAY_WIDTH * DISPLAY_HEIGHT) + 1;
    localparam int CW = 18;

    // frame store
    logic [7:0] r_mem [FrameBytes];
    logic [7:0] r_rd_data;
    logic       mem_we;
    logic [FaW-1:0] mem_waddr, mem_raddr;
    logic [7:0] mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    // control registers
    t_state r_state, n_state;
    logic [1:0] r_color, n_color;
    logic [FaW-1:0] r_cnt, n_cnt;
    logic signed [CW-1:0] r_x, n_x, r_y, n_y, r_x2, n_x2, r_y2, n_y2;
    logic signed [CW-1:0] r_fx0, n_fx0, r_fx1, n_fx1, r_fy1, n_fy1;
    logic signed [CW+1:0] r_err, n_err;
    logic signed [CW-1:0] r_dx, n_dx, r_dy, n_dy;
    logic r_sx, n_sx, r_sy, n_sy;
    logic [2:0] r_seg, n_seg;
    logic [1:0] r_lines, n_lines;
    logic signed [CW-1:0] r_ax, n_ax, r_ay, n_ay, r_bx, n_bx, r_by, n_by;
    logic [PixW-1:0] r_pix, n_pix;
    logic r_inb, n_inb;
    logic r_ovalid, n_ovalid;
    t_res r_res, n_res;
    logic [AddrW-1:0] r_raddr, n_raddr;
    logic r_raddr_kind_rd;
    logic r_started;

    // pixel index of current point from one multiply, registered by fill and line states
    logic signed [CW-1:0] cur_x, cur_y;
    logic cur_in;
    logic [PixW-1:0] cur_pix;
    logic [PixW-1:0] row_base;
    assign row_base = PixW'(cur_y[CW-2:0] * DISPLAY_WIDTH);
    assign cur_pix = row_base + PixW'(cur_x[CW-2:0]);
    assign cur_in = (cur_x >= 0) && (cur_x < CW'(DISPLAY_WIDTH))
                 && (cur_y >= 0) && (cur_y < CW'(DISPLAY_HEIGHT));

    // pixel merge
    logic [2:0] sh;
    logic [7:0] merged;
    logic [1:0] pxv;
    assign pxv = 2'd3 - r_color;
    assign sh = {2'd3 - r_pix[1:0], 1'b0};
    assign merged = (r_rd_data & ~(8'h03 << sh)) | ({6'd0, pxv} << sh);

    // line segment endpoints for outline
    logic signed [CW-1:0] sx1, sy1, sx2, sy2, axw, ayh;
    assign axw = r_ax + r_bx;
    assign ayh = r_ay + r_by;
    always_comb begin
        sx1 = r_ax; sy1 = r_ay; sx2 = axw; sy2 = r_ay;
        case (r_lines)
            2'd0: begin sx1 = r_ax; sy1 = r_ay; sx2 = axw;  sy2 = r_ay; end
            2'd1: begin sx1 = axw;  sy1 = r_ay; sx2 = axw;  sy2 = ayh;  end
            2'd2: begin sx1 = axw;  sy1 = ayh;  sx2 = r_ax; sy2 = ayh;  end
            default: begin sx1 = r_ax; sy1 = ayh; sx2 = r_ax; sy2 = r_ay; end
        endcase
    end

    logic signed [CW+1:0] e2;
    assign e2 = r_err <<< 1;

    assign i_cmd.ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_res.valid = r_ovalid;
    assign o_res.data = r_res;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid && i_cmd.ready) begin
                    unique case (t_kind'(i_cmd.data.kind)) inside
                        K_CLEAR: n_state = S_CLEAR;
                        K_FILL:  n_state = S_FILL_ROW;
                        K_LINE, K_RECT: n_state = S_LINE_SETUP;
                        K_READ:  n_state = S_READ;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_CLEAR: if (r_cnt == FaW'(FrameBytes - 1)) n_state = S_DONE;
            S_FILL_ROW: begin
                if (r_y >= r_fy1) n_state = S_DONE;
                else if (r_fx0 >= r_fx1) n_state = S_DONE;
                else n_state = S_FILL_RD;
            end
            S_FILL_RD: n_state = S_FILL_WR;
            S_FILL_WR: n_state = (r_x + CW'(1) >= r_fx1) ? S_FILL_ROW : S_FILL_RD;
            S_LINE_SETUP: n_state = S_LINE_RD;
            S_LINE_RD: n_state = S_LINE_WR;
            S_LINE_WR: begin
                if (r_x == r_x2 && r_y == r_y2)
                    n_state = (r_seg != 3'd0 && r_lines != 2'd3) ? S_LINE_SETUP : S_DONE;
                else n_state = S_LINE_RD;
            end
            S_READ: n_state = S_READ_WAIT;
            S_READ_WAIT: n_state = S_DONE;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_color = r_color; n_cnt = r_cnt; n_x = r_x; n_y = r_y; n_x2 = r_x2;
        n_y2 = r_y2; n_fx0 = r_fx0; n_fx1 = r_fx1; n_fy1 = r_fy1; n_err = r_err;
        n_dx = r_dx; n_dy = r_dy; n_sx = r_sx; n_sy = r_sy; n_seg = r_seg;
        n_lines = r_lines; n_ax = r_ax; n_ay = r_ay; n_bx = r_bx; n_by = r_by;
        n_pix = r_pix; n_inb = r_inb; n_ovalid = r_ovalid; n_res = r_res;
        n_raddr = r_raddr;
        mem_we = 1'b0; mem_waddr = r_cnt; mem_wdata = ByteWhite;
        mem_raddr = FaW'(r_pix >> 2);
        cur_x = r_x; cur_y = r_y;
        if (o_res.valid && o_res.ready) n_ovalid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (i_cmd.valid && i_cmd.ready) begin
                    n_ax = CW'(signed'(i_cmd.data.start_x));
                    n_ay = CW'(signed'(i_cmd.data.start_y));
                    n_bx = CW'(signed'(i_cmd.data.end_x_or_width));
                    n_by = CW'(signed'(i_cmd.data.end_y_or_height));
                    n_raddr = i_cmd.data.byte_address;
                    n_lines = 2'd0;
                    n_seg = (i_cmd.data.kind == K_RECT) ? 3'd1 : 3'd0;
                    if (i_cmd.data.kind == K_COLOR) n_color = i_cmd.data.new_color;
                    if (i_cmd.data.kind == K_FILL) begin
                        n_fx0 = (i_cmd.data.start_x[15]) ? '0
                              : CW'(signed'(i_cmd.data.start_x));
                        n_y = (i_cmd.data.start_y[15]) ? '0
                            : CW'(signed'(i_cmd.data.start_y));
                        n_fx1 = CW'(signed'(i_cmd.data.start_x))
                              + CW'(signed'(i_cmd.data.end_x_or_width));
                        n_fy1 = CW'(signed'(i_cmd.data.start_y))
                              + CW'(signed'(i_cmd.data.end_y_or_height));
                        if (n_fx1 > CW'(DISPLAY_WIDTH)) n_fx1 = CW'(DISPLAY_WIDTH);
                        if (n_fy1 > CW'(DISPLAY_HEIGHT)) n_fy1 = CW'(DISPLAY_HEIGHT);
                    end
                end
            end
            S_CLEAR: begin
                mem_we = 1'b1;
                n_cnt = r_cnt + 1'b1;
                n_color = ColorBlack;
            end
            S_FILL_ROW: begin
                n_x = r_fx0;
                cur_x = r_fx0;
                n_pix = cur_pix;
                n_inb = 1'b1;
            end
            S_FILL_RD: mem_raddr = FaW'(r_pix >> 2);
            S_FILL_WR: begin
                mem_we = 1'b1;
                mem_waddr = FaW'(r_pix >> 2);
                mem_wdata = merged;
                n_x = r_x + CW'(1);
                n_pix = r_pix + 1'b1;
                if (r_x + CW'(1) >= r_fx1) n_y = r_y + CW'(1);
            end
            S_LINE_SETUP: begin
                n_x = (r_seg != 3'd0) ? sx1 : r_ax;
                n_y = (r_seg != 3'd0) ? sy1 : r_ay;
                n_x2 = (r_seg != 3'd0) ? sx2 : r_bx;
                n_y2 = (r_seg != 3'd0) ? sy2 : r_by;
                n_dx = (n_x2 > n_x) ? n_x2 - n_x : n_x - n_x2;
                n_dy = (n_y2 > n_y) ? n_y2 - n_y : n_y - n_y2;
                n_sx = n_x < n_x2;
                n_sy = n_y < n_y2;
                n_err = (CW+2)'(n_dx) - (CW+2)'(n_dy);
                cur_x = n_x; cur_y = n_y;
                n_pix = cur_pix; n_inb = cur_in;
            end
            S_LINE_RD: mem_raddr = FaW'(r_pix >> 2);
            S_LINE_WR: begin
                mem_we = r_inb;
                mem_waddr = FaW'(r_pix >> 2);
                mem_wdata = merged;
                if (e2 > -(CW+2)'(r_dy) && e2 < (CW+2)'(r_dx)) begin
                    n_err = r_err - (CW+2)'(r_dy) + (CW+2)'(r_dx);
                end else if (e2 > -(CW+2)'(r_dy)) begin
                    n_err = r_err - (CW+2)'(r_dy);
                end else if (e2 < (CW+2)'(r_dx)) begin
                    n_err = r_err + (CW+2)'(r_dx);
                end
                if (e2 > -(CW+2)'(r_dy)) n_x = r_sx ? r_x + CW'(1) : r_x - CW'(1);
                if (e2 < (CW+2)'(r_dx)) n_y = r_sy ? r_y + CW'(1) : r_y - CW'(1);
                cur_x = n_x; cur_y = n_y;
                n_pix = cur_pix; n_inb = cur_in;
                if (r_x == r_x2 && r_y == r_y2) n_lines = r_lines + 1'b1;
            end
            S_READ: mem_raddr = FaW'(r_raddr);
            S_READ_WAIT: begin
                n_res.read_byte = (r_raddr < AddrW'(FrameBytes)) ? r_rd_data : 8'd0;
            end
            S_DONE: begin
                n_ovalid = 1'b1;
                n_res.color_now = r_color;
            end
            default: ;
        endcase
        if (r_state == S_DONE && r_raddr_kind_rd == 1'b0) n_res.read_byte = 8'd0;
    end

    // remember whether the current command is a byte read
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_cmd.valid && i_cmd.ready) begin
            r_raddr_kind_rd <= (i_cmd.data.kind == K_READ);
        end
    end

    // register update, reset starts a clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt <= '0;
            r_color <= ColorBlack;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= (r_state == S_CLEAR && n_state == S_DONE && !r_started)
                     ? S_IDLE : n_state;
            r_cnt <= n_cnt;
            r_color <= n_color;
            r_ovalid <= n_ovalid;
        end
    end

    // distinguishes a clear command from the reset clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
        end else if (i_cmd.valid && i_cmd.ready) begin
            r_started <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x; r_y <= n_y; r_x2 <= n_x2; r_y2 <= n_y2;
        r_fx0 <= n_fx0; r_fx1 <= n_fx1; r_fy1 <= n_fy1; r_err <= n_err;
        r_dx <= n_dx; r_dy <= n_dy; r_sx <= n_sx; r_sy <= n_sy;
        r_seg <= n_seg; r_lines <= n_lines; r_ax <= n_ax; r_ay <= n_ay;
        r_bx <= n_bx; r_by <= n_by; r_pix <= n_pix; r_inb <= n_inb;
        r_res <= n_res; r_raddr <= n_raddr;
    end
endmodule
`default_nettype wire

@@ design/p2rde_checker.sv @@
// port-level checker for the raster draw engine and its bind
`default_nettype none
`include "assert_macros.svh"
module p2rde_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic cmd_valid,
    input wire logic cmd_ready,
    input wire logic res_valid,
    input wire logic res_ready,
    input wire logic [1:0] color_now
);
    `CHK_IMPLY(a_no_take_while_res, i_clk, i_rst_n, res_valid, !cmd_ready, "command taken with result pending")
    `CHK_NEXT(a_res_hold, i_clk, i_rst_n, res_valid && !res_ready, res_valid, "result dropped under stall")
    `CHK_NEXT(a_color_hold, i_clk, i_rst_n, res_valid && !res_ready, $stable(color_now), "result changed under stall")
    `CHK_NEXT(a_one_cmd, i_clk, i_rst_n, cmd_valid && cmd_ready, !cmd_ready, "two commands in a row")
endmodule

bind packed_2bpp_raster_draw_engine_unit p2rde_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .cmd_valid(i_cmd.valid), .cmd_ready(i_cmd.ready),
    .res_valid(o_res.valid), .res_ready(o_res.ready),
    .color_now(o_res.data.color_now)
);
`default_nettype wire

@@ tb/sv/tb.sv @@
// self-checking testbench for the packed 2bpp raster draw engine
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import p2rde_pkg::*;

    localparam int FB_W     = 800;
    localparam int FB_H     = 480;
    localparam int FB_BYTES = (FB_W * FB_H + 3) / 4;
    localparam int N_RANDOM = 730;

    logic i_clk;
    logic i_rst_n;

    p2rde_cmd_if cmd_if ();
    p2rde_res_if res_if ();

    packed_2bpp_raster_draw_engine_unit #(
        .DISPLAY_WIDTH  (FB_W),
        .DISPLAY_HEIGHT (FB_H)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if.sink),
        .o_res   (res_if.source)
    );

    // shadow of the frame store and pen colour
    logic [7:0] shadow_frame [FB_BYTES];
    logic [1:0] shadow_pen;

    t_cmd pending_cmds [$];
    t_res expected_words [$];
    int n_errors;
    int n_accepted;
    int n_total;
    int n_checked;
    int kind_seen [8];
    int last_x;
    int last_y;

    // clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // shadow frame painting
    function automatic void plot_pixel(int x, int y);
        int p;
        int b;
        int sh;
        logic [7:0] mask;
        logic [7:0] px;
        if (x < 0 || x >= FB_W || y < 0 || y >= FB_H) return;
        p = y * FB_W + x;
        b = p >> 2;
        if (b >= FB_BYTES) return;
        sh = (3 - (p & 3)) * 2;
        mask = 8'h03 << sh;
        px = {6'd0, 2'd3 - shadow_pen} << sh;
        shadow_frame[b] = (shadow_frame[b] & ~mask) | px;
    endfunction

    function automatic void trace_line(int x1, int y1, int x2, int y2);
        int dx;
        int dy;
        int sx;
        int sy;
        int err;
        int e2;
        dx = (x2 > x1) ? x2 - x1 : x1 - x2;
        dy = (y2 > y1) ? y2 - y1 : y1 - y2;
        sx = (x1 < x2) ? 1 : -1;
        sy = (y1 < y2) ? 1 : -1;
        err = dx - dy;
        forever begin
            plot_pixel(x1, y1);
            if (x1 == x2 && y1 == y2) break;
            e2 = 2 * err;
            if (e2 > -dy) begin
                err -= dy;
                x1 += sx;
            end
            if (e2 < dx) begin
                err += dx;
                y1 += sy;
            end
        end
    endfunction

    function automatic void fill_area(int x, int y, int w, int h);
        int x0;
        int y0;
        int x1;
        int y1;
        x0 = (x < 0) ? 0 : x;
        y0 = (y < 0) ? 0 : y;
        x1 = x + w;
        y1 = y + h;
        if (x1 > FB_W) x1 = FB_W;
        if (y1 > FB_H) y1 = FB_H;
        for (int r = y0; r < y1; r++)
            for (int c = x0; c < x1; c++)
                plot_pixel(c, r);
    endfunction

    // apply one command to the shadow state and return the expected word
    function automatic t_res paint_and_read(t_cmd c);
        t_res r;
        int ax;
        int ay;
        int bx;
        int by;
        ax = int'($signed(c.start_x));
        ay = int'($signed(c.start_y));
        bx = int'($signed(c.end_x_or_width));
        by = int'($signed(c.end_y_or_height));
        r.read_byte = 8'h00;
        case (t_kind'(c.kind))
            K_CLEAR: begin
                foreach (shadow_frame[i]) shadow_frame[i] = ByteWhite;
                shadow_pen = ColorBlack;
            end
            K_COLOR: shadow_pen = c.new_color;
            K_FILL:  fill_area(ax, ay, bx, by);
            K_LINE:  trace_line(ax, ay, bx, by);
            K_RECT: begin
                trace_line(ax, ay, ax + bx, ay);
                trace_line(ax + bx, ay, ax + bx, ay + by);
                trace_line(ax + bx, ay + by, ax, ay + by);
                trace_line(ax, ay + by, ax, ay);
            end
            K_READ: begin
                if (c.byte_address < FB_BYTES) r.read_byte = shadow_frame[c.byte_address];
            end
            default: ;
        endcase
        r.color_now = shadow_pen;
        return r;
    endfunction

    task automatic queue_cmd(t_kind k, int ax, int ay, int bx, int by, int col, int addr);
        t_cmd c;
        c.kind = k;
        c.start_x = ax[15:0];
        c.start_y = ay[15:0];
        c.end_x_or_width = bx[15:0];
        c.end_y_or_height = by[15:0];
        c.new_color = col[1:0];
        c.byte_address = addr[16:0];
        pending_cmds.push_back(c);
    endtask

    // command with every field random apart from the kind
    task automatic queue_noise(t_kind k);
        queue_cmd(k, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    // read one byte near the last drawing position
    task automatic queue_nearby_read();
        int a;
        int cx;
        int cy;
        cx = (last_x < 0) ? 0 : (last_x >= FB_W) ? FB_W - 1 : last_x;
        cy = (last_y < 0) ? 0 : (last_y >= FB_H) ? FB_H - 1 : last_y;
        a = (cy * FB_W + cx) / 4 + $urandom_range(0, 6) - 3;
        if (a < 0) a = 0;
        queue_cmd(K_READ, $urandom, $urandom, $urandom, $urandom, $urandom, a);
    endtask

    function automatic int rnd(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    task automatic queue_random_cmd();
        int sel;
        int x;
        int y;
        sel = $urandom_range(0, 999);
        x = rnd(-20, FB_W + 20);
        y = rnd(-20, FB_H + 20);
        if (sel < 3) begin
            queue_noise(K_CLEAR);
        end else if (sel < 100) begin
            queue_noise(K_COLOR);
        end else if (sel < 250) begin
            last_x = x;
            last_y = y;
            if ($urandom_range(0, 19) == 0)
                queue_cmd(K_FILL, x, y, rnd(-5, 900), rnd(1, 2), $urandom, $urandom);
            else
                queue_cmd(K_FILL, x, y, rnd(-3, 16), rnd(-3, 16), $urandom, $urandom);
        end else if (sel < 480) begin
            last_x = x;
            last_y = y;
            if ($urandom_range(0, 4) == 0)
                queue_cmd(K_LINE, x, y, rnd(-50, FB_W + 50), rnd(-50, FB_H + 50),
                          $urandom, $urandom);
            else
                queue_cmd(K_LINE, x, y, x + rnd(-40, 40), y + rnd(-40, 40),
                          $urandom, $urandom);
        end else if (sel < 600) begin
            last_x = x;
            last_y = y;
            queue_cmd(K_RECT, x, y, rnd(-20, 20), rnd(-20, 20), $urandom, $urandom);
        end else if (sel < 800) begin
            queue_nearby_read();
        end else if (sel < 900) begin
            queue_cmd(K_READ, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom_range(0, FB_BYTES - 1));
        end else if (sel < 950) begin
            queue_noise(K_READ);
        end else begin
            queue_noise(($urandom_range(0, 1) != 0) ? K_NOP6 : K_NOP7);
        end
    endtask

    // stimulus and end of run
    initial begin
        i_rst_n = 1'b0;
        cmd_if.valid = 1'b0;
        cmd_if.data = '0;
        res_if.ready = 1'b0;
        n_errors = 0;
        n_accepted = 0;
        n_checked = 0;
        last_x = 0;
        last_y = 0;
        foreach (kind_seen[i]) kind_seen[i] = 0;
        foreach (shadow_frame[i]) shadow_frame[i] = ByteWhite;
        shadow_pen = ColorBlack;

        // directed: extremes and corner cases
        queue_cmd(K_READ, 0, 0, 0, 0, 0, 0);
        queue_cmd(K_READ, 0, 0, 0, 0, 0, FB_BYTES - 1);
        queue_cmd(K_READ, 0, 0, 0, 0, 0, FB_BYTES);
        queue_cmd(K_READ, -1, -1, -1, -1, 3, 17'h1FFFF);
        queue_cmd(K_COLOR, 0, 0, 0, 0, 0, 0);
        queue_cmd(K_FILL, -5, -5, 12, 9, 0, 0);
        queue_cmd(K_READ, 0, 0, 0, 0, 0, 0);
        queue_cmd(K_FILL, FB_W - 5, FB_H - 5, 32767, 32767, 0, 0);
        queue_cmd(K_READ, 0, 0, 0, 0, 0, FB_BYTES - 1);
        queue_cmd(K_FILL, 10, 10, 0, 5, 0, 0);
        queue_cmd(K_FILL, 10, 10, -32768, -32768, 0, 0);
        queue_cmd(K_FILL, -32768, -32768, 32767, 32767, 0, 0);
        queue_cmd(K_COLOR, 0, 0, 0, 0, 2, 0);
        queue_cmd(K_LINE, -32768, -32768, 32767, 32767, 0, 0);
        queue_cmd(K_READ, 0, 0, 0, 0, 0, 0);
        queue_cmd(K_LINE, 7, 3, 7, 3, 0, 0);
        queue_cmd(K_READ, 0, 0, 0, 0, 0, (3 * FB_W + 7) / 4);
        queue_cmd(K_COLOR, 0, 0, 0, 0, 1, 0);
        queue_cmd(K_RECT, FB_W - 10, FB_H - 10, 20, 20, 0, 0);
        queue_cmd(K_RECT, 30, 30, -12, -7, 0, 0);
        queue_cmd(K_RECT, 32760, 32760, 30, 30, 0, 0);
        queue_cmd(K_READ, 0, 0, 0, 0, 0, (30 * FB_W + 20) / 4);
        queue_noise(K_NOP6);
        queue_noise(K_NOP7);
        queue_cmd(K_CLEAR, 0, 0, 0, 0, 0, 0);
        queue_cmd(K_READ, 0, 0, 0, 0, 0, (30 * FB_W + 20) / 4);

        for (int i = 0; i < N_RANDOM; i++) queue_random_cmd();
        n_total = pending_cmds.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (n_accepted == n_total && expected_words.size() == 0);
        repeat (50) @(posedge i_clk);
        $display("run covered %0d commands: clear %0d, colour %0d, fill %0d, line %0d,",
                 n_total, kind_seen[K_CLEAR], kind_seen[K_COLOR], kind_seen[K_FILL],
                 kind_seen[K_LINE]);
        $display("outline %0d, read %0d, unused %0d; %0d words checked, %0d errors",
                 kind_seen[K_RECT], kind_seen[K_READ], kind_seen[K_NOP6] + kind_seen[K_NOP7],
                 n_checked, n_errors);
        if (n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // command driver with random gaps and gap-free stretches
    int cmd_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
            cmd_gap <= 0;
        end else if (!(cmd_if.valid && !cmd_if.ready)) begin
            if (cmd_if.valid) begin
                expected_words.push_back(paint_and_read(cmd_if.data));
                kind_seen[cmd_if.data.kind]++;
                n_accepted++;
            end
            if (cmd_gap > 0) begin
                cmd_gap <= cmd_gap - 1;
                cmd_if.valid <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
                cmd_if.valid <= 1'b1;
                cmd_if.data <= pending_cmds.pop_front();
                cmd_gap <= (((n_accepted / 64) % 4) == 1) ? 0 : $urandom_range(0, 4);
            end else begin
                cmd_if.valid <= 1'b0;
            end
        end
    end

    // result monitor and checker with random stalls
    int res_stall;
    int res_draw;
    t_res want;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            res_stall <= 1;
        end else if (res_if.valid && res_if.ready) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual byte %02h colour %0d",
                         $time, res_if.data.read_byte, res_if.data.color_now);
                n_errors++;
            end else begin
                want = expected_words.pop_front();
                if (res_if.data.read_byte !== want.read_byte) begin
                    $display("%0t: read_byte mismatch, expected %02h, actual %02h",
                             $time, want.read_byte, res_if.data.read_byte);
                    n_errors++;
                end
                if (res_if.data.color_now !== want.color_now) begin
                    $display("%0t: color_now mismatch, expected %0d, actual %0d",
                             $time, want.color_now, res_if.data.color_now);
                    n_errors++;
                end
                n_checked++;
            end
            res_draw = (((n_checked / 64) % 4) == 2) ? 0 : $urandom_range(0, 4);
            res_stall <= res_draw;
            res_if.ready <= (res_draw == 0);
        end else if (res_stall > 0) begin
            res_stall <= res_stall - 1;
            res_if.ready <= (res_stall == 1);
        end
    end

    // watchdog
    initial begin
        #50000000;
        $display("timeout with %0d of %0d commands taken", n_accepted, n_total);
        $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire

@@ sim.f @@
+incdir+design
design/p2rde_pkg.sv
design/p2rde_if.sv
design/packed_2bpp_raster_draw_engine_unit.sv
design/p2rde_checker.sv
tb/sv/tb.sv
